### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by the RTL files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

### rtl/asl_pkg.sv
// ---------------------------------------------------------------------------
// asl_pkg
// Constants and types of the address range symbol lookup.
// ---------------------------------------------------------------------------
package asl_pkg;

    localparam int MAX_SYMBOLS      = 1024;
    localparam int ADDR_BITS        = 32;
    localparam int NAME_OFFSET_BITS = 16;
    localparam int IDX_W            = $clog2(MAX_SYMBOLS);
    localparam int CNT_W            = IDX_W + 1;
    localparam int FIELD_IDX_W      = 10;
    localparam int COUNT_REG_W      = 11;

    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_SYMBOLS);

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    localparam logic REG_SYMBOL_COUNT   = 1'b0;
    localparam logic REG_TABLE_SUPPLIED = 1'b1;

    typedef struct packed {
        logic [ADDR_BITS-1:0]        start;
        logic [NAME_OFFSET_BITS-1:0] name;
    } entry_t;

endpackage

### rtl/asl_ram.sv
// ---------------------------------------------------------------------------
// asl_ram
// Generic single-port synchronous RAM with a registered read.
// ---------------------------------------------------------------------------
module asl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### rtl/address_range_symbol_lookup.sv
// ---------------------------------------------------------------------------
// address_range_symbol_lookup
// Resolves a query address to the table symbol whose range holds it.
// ---------------------------------------------------------------------------
// An item is taken at a clock edge where start is high and busy is low.
// A load item (mode 0) writes one table entry in that cycle; busy stays low
// and no result follows, so loads can be issued back to back.
// A lookup item (mode 1) runs a binary search over the table memory, one
// probe per cycle, with the compare of one probe selecting the next read
// address of the single memory port. The result strobe done rises in the
// cycle after the last probe, and busy stays high until then, so no new
// item is taken during a search. Without a supplied table, or with a zero
// count, the result comes in the cycle right after acceptance.
// Each result is shown for exactly one cycle with done high; the receiver
// cannot stall it. busy is low again while the strobe is shown.
// Reset sets symbol_count to 1 and table_supplied to 0; the table memory
// holds no defined contents until entries are loaded.
// Configuration goes through the APB port; pready is always high.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module address_range_symbol_lookup (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [9:0]  entry_index,
    input  logic [31:0] entry_start,
    input  logic [15:0] entry_name_offset,
    input  logic [31:0] query_addr,
    output logic        done,
    output logic        found,
    output logic [9:0]  symbol_index,
    output logic [31:0] symbol_start,
    output logic [15:0] name_offset,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [0:0] {ST_IDLE, ST_SEARCH} state_t;

    state_t state_reg;

    logic [asl_pkg::COUNT_REG_W-1:0]      symbol_count_reg;
    logic                                 table_supplied_reg;
    logic [asl_pkg::CNT_W-1:0]            lo_reg;
    logic [asl_pkg::CNT_W-1:0]            n_reg;
    logic [asl_pkg::IDX_W-1:0]            probe_reg;
    logic [asl_pkg::ADDR_BITS-1:0]        query_reg;
    logic                                 hit_reg;
    logic [asl_pkg::IDX_W-1:0]            hit_idx_reg;
    logic [asl_pkg::ADDR_BITS-1:0]        hit_start_reg;
    logic [asl_pkg::NAME_OFFSET_BITS-1:0] hit_name_reg;
    logic                                 done_reg;
    logic                                 found_reg;
    logic [asl_pkg::FIELD_IDX_W-1:0]      symbol_index_reg;
    logic [asl_pkg::ADDR_BITS-1:0]        symbol_start_reg;
    logic [asl_pkg::NAME_OFFSET_BITS-1:0] name_offset_reg;

    logic                                 accept;
    logic                                 cfg_write;
    logic [asl_pkg::CNT_W-1:0]            count_sat;
    logic [asl_pkg::CNT_W-1:0]            count_half;
    logic [asl_pkg::CNT_W-1:0]            half;
    logic                                 take;
    logic [asl_pkg::CNT_W-1:0]            lo_next;
    logic [asl_pkg::CNT_W-1:0]            n_next;
    logic [asl_pkg::CNT_W-1:0]            probe_sum;
    logic [asl_pkg::IDX_W-1:0]            probe_next;
    logic                                 fin_found;
    logic [asl_pkg::IDX_W-1:0]            fin_idx;
    logic [asl_pkg::ADDR_BITS-1:0]        fin_start;
    logic [asl_pkg::NAME_OFFSET_BITS-1:0] fin_name;
    logic                                 ram_we;
    logic [asl_pkg::IDX_W-1:0]            ram_addr;
    asl_pkg::entry_t                      ram_wdata;
    logic [$bits(asl_pkg::entry_t)-1:0]   ram_rdata;
    asl_pkg::entry_t                      rd;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb
    begin
        case (paddr[2])
            asl_pkg::REG_SYMBOL_COUNT:
                prdata = {{(32 - asl_pkg::COUNT_REG_W){1'b0}}, symbol_count_reg};
            asl_pkg::REG_TABLE_SUPPLIED:
                prdata = {31'b0, table_supplied_reg};
            default:
                prdata = '0;
        endcase
    end

    always_comb
    begin
        if (symbol_count_reg > asl_pkg::COUNT_REG_W'(asl_pkg::MAX_COUNT))
        begin
            count_sat = asl_pkg::MAX_COUNT;
        end
        else
        begin
            count_sat = asl_pkg::CNT_W'(symbol_count_reg);
        end
    end

    assign count_half = count_sat >> 1;
    assign rd         = asl_pkg::entry_t'(ram_rdata);
    assign half       = n_reg >> 1;
    assign take       = (rd.start <= query_reg);
    assign lo_next    = take ? ({1'b0, probe_reg} + asl_pkg::CNT_W'(1)) : lo_reg;
    assign n_next     = take ? (n_reg - half - asl_pkg::CNT_W'(1)) : half;
    assign probe_sum  = lo_next + (n_next >> 1);
    assign probe_next = probe_sum[asl_pkg::IDX_W-1:0];

    assign fin_found = take || hit_reg;
    assign fin_idx   = take ? probe_reg : hit_idx_reg;
    assign fin_start = take ? rd.start : hit_start_reg;
    assign fin_name  = take ? rd.name : hit_name_reg;

    assign ram_we          = accept && (mode == asl_pkg::MODE_LOAD)
                             && ({1'b0, entry_index} < 11'(asl_pkg::MAX_SYMBOLS));
    assign ram_wdata.start = entry_start;
    assign ram_wdata.name  = entry_name_offset;

    always_comb
    begin
        if (state_reg == ST_SEARCH)
        begin
            ram_addr = probe_next;
        end
        else if (mode == asl_pkg::MODE_LOAD)
        begin
            ram_addr = entry_index[asl_pkg::IDX_W-1:0];
        end
        else
        begin
            ram_addr = count_half[asl_pkg::IDX_W-1:0];
        end
    end

    asl_ram #(
        .WIDTH ($bits(asl_pkg::entry_t)),
        .DEPTH (asl_pkg::MAX_SYMBOLS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            symbol_count_reg   <= asl_pkg::COUNT_REG_W'(1);
            table_supplied_reg <= 1'b0;
            hit_reg            <= 1'b0;
            done_reg           <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_write)
            begin
                case (paddr[2])
                    asl_pkg::REG_SYMBOL_COUNT:
                        symbol_count_reg <= pwdata[asl_pkg::COUNT_REG_W-1:0];
                    asl_pkg::REG_TABLE_SUPPLIED:
                        table_supplied_reg <= pwdata[0];
                    default:
                        ;
                endcase
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (mode == asl_pkg::MODE_LOOKUP))
                    begin
                        if (!table_supplied_reg || (count_sat == '0))
                        begin
                            done_reg         <= 1'b1;
                            found_reg        <= !table_supplied_reg;
                            symbol_index_reg <= '0;
                            symbol_start_reg <= '0;
                            name_offset_reg  <= '0;
                        end
                        else
                        begin
                            state_reg <= ST_SEARCH;
                            lo_reg    <= '0;
                            n_reg     <= count_sat;
                            probe_reg <= count_half[asl_pkg::IDX_W-1:0];
                            query_reg <= query_addr;
                            hit_reg   <= 1'b0;
                        end
                    end
                end
                ST_SEARCH:
                begin
                    lo_reg    <= lo_next;
                    n_reg     <= n_next;
                    probe_reg <= probe_next;
                    if (take)
                    begin
                        hit_reg       <= 1'b1;
                        hit_idx_reg   <= probe_reg;
                        hit_start_reg <= rd.start;
                        hit_name_reg  <= rd.name;
                    end
                    if (n_next == '0)
                    begin
                        state_reg <= ST_IDLE;
                        done_reg  <= 1'b1;
                        found_reg <= fin_found;
                        if (fin_found)
                        begin
                            symbol_index_reg <= asl_pkg::FIELD_IDX_W'(fin_idx);
                            symbol_start_reg <= fin_start;
                            name_offset_reg  <= fin_name;
                        end
                        else
                        begin
                            symbol_index_reg <= '0;
                            symbol_start_reg <= '0;
                            name_offset_reg  <= '0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done         = done_reg;
    assign found        = found_reg;
    assign symbol_index = symbol_index_reg;
    assign symbol_start = symbol_start_reg;
    assign name_offset  = name_offset_reg;

    `ASSERT_PROP(a_search_nonempty, (state_reg == ST_SEARCH) |-> (n_reg != '0), "Search with empty span")
    `ASSERT_PROP(a_probe_in_range, (state_reg == ST_SEARCH) |-> ({1'b0, probe_reg} < count_sat), "Probe beyond count")
    `ASSERT_PROP(a_default_answer, (accept && (mode == asl_pkg::MODE_LOOKUP) && !table_supplied_reg) |=> (done && found), "Default lookup gave no hit")
    `ASSERT_PROP(a_miss_zero, (done && !found) |-> ((symbol_index == '0) && (symbol_start == '0) && (name_offset == '0)), "Miss with nonzero fields")
    `ASSERT_NEVER(a_busy_done, busy && done, "Result shown while busy")

endmodule
